[rtl/tcc_pkg.sv]
// Shared types and constants for the text console cursor/scroll engine.
// Used by text_console_cursor_scroll and its testbench; no dependencies.
package tcc_pkg;

    localparam int TCC_ROWS = 25;
    localparam int TCC_COLS = 80;

    localparam logic [7:0] NEWLINE_CODE      = 8'd10;
    localparam logic [7:0] BLANK_CODE        = 8'd32;
    localparam logic [7:0] DEFAULT_COLOR_RST = 8'd7;

    localparam int CELL_W = 16;

    typedef enum logic [2:0] {
        OP_PUT   = 3'd0,
        OP_SET   = 3'd1,
        OP_CLEAR = 3'd2,
        OP_HOME  = 3'd3,
        OP_READ  = 3'd4
    } tcc_op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL
    } tcc_state_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] char_code;
        logic [7:0] color;
        logic [4:0] row;
        logic [6:0] col;
    } tcc_in_t;

    typedef struct packed {
        logic [4:0]        cursor_row;
        logic [6:0]        cursor_col;
        logic [CELL_W-1:0] cell_word;
    } tcc_out_t;

endpackage

[rtl/tcc_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module tcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/text_console_cursor_scroll.sv]
// Text console engine: screen store in tcc_ram, cursor and sequencer here.
// Depends on tcc_pkg and tcc_ram.
//
//   channel   ports                          direction   payload
//   input     s_valid / s_ready / s_data     in          tcc_in_t
//   result    m_valid / m_ready / m_data     out         tcc_out_t
//   config    cfg_wr_en / cfg_wr_data        in          default color byte
//
// Put char, set cursor, home and unused codes stay in idle; read cell passes through a read state.
// Clear line of a row in range fills its COLS cells; a newline on the bottom row copies (ROWS-1)*COLS
// cells one per cycle, then fills the last row.
// After reset a clearing pass zeroes the store, ROWS*2**$clog2(COLS) words
// ({row, col} addressing), 3200 words at 25x80, during which no item is taken.
// A waiting result holds off the next item until it transfers in that cycle.
module text_console_cursor_scroll
    import tcc_pkg::*;
#(
    parameter int ROWS = TCC_ROWS,
    parameter int COLS = TCC_COLS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  tcc_in_t   s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output tcc_out_t  m_data,
    input  logic      cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int CCW   = $clog2(COLS + 1);
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS * (2 ** CW);

    tcc_state_t state_reg, state_next;

    logic [RW-1:0]     cur_row_reg, cur_row_next;
    logic [CCW-1:0]    cur_col_reg, cur_col_next;
    logic [7:0]        color_reg;
    logic [RW-1:0]     idx_row_reg, idx_row_next;
    logic [CW-1:0]     idx_col_reg, idx_col_next;
    logic [AW-1:0]     clr_addr_reg;
    logic [CELL_W-1:0] fill_word_reg, fill_word_next;
    logic              cp_valid_reg;
    logic [AW-1:0]     cp_addr_reg;
    logic              rd_ok_reg, rd_ok_next;
    logic              m_valid_reg, m_valid_next;
    tcc_out_t          m_data_reg, m_data_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    logic          s_accept;
    logic          at_bottom;
    logic          wrap;
    logic          is_newline;
    logic          row_ok;
    logic          col_ok;
    logic [RW-1:0] put_row;
    logic [CW-1:0] put_col;
    logic          clr_last;
    logic          scroll_last;
    logic          fill_last;
    logic          fill_we;

    assign s_ready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_accept = s_valid && s_ready;

    assign at_bottom  = (cur_row_reg == RW'(ROWS - 1));
    assign wrap       = (cur_col_reg == CCW'(COLS));
    assign is_newline = (s_data.char_code == NEWLINE_CODE);
    assign row_ok     = (32'(s_data.row) < ROWS);
    assign col_ok     = (32'(s_data.col) < COLS);
    assign put_row    = (wrap && !at_bottom) ? cur_row_reg + RW'(1) : cur_row_reg;
    assign put_col    = wrap ? '0 : CW'(cur_col_reg);

    assign clr_last    = (clr_addr_reg == AW'(DEPTH - 1));
    assign scroll_last = (idx_row_reg == RW'(ROWS - 2)) && (idx_col_reg == CW'(COLS - 1));
    assign fill_last   = (idx_col_reg == CW'(COLS - 1));
    // A copy write left over from the scroll takes the write port first.
    assign fill_we     = (state_reg == ST_FILL) && !cp_valid_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (s_data.cmd)
                        OP_PUT: begin
                            if (is_newline && at_bottom) begin
                                state_next = ST_SCROLL;
                            end
                        end
                        OP_CLEAR: begin
                            if (row_ok) begin
                                state_next = ST_FILL;
                            end
                        end
                        OP_READ: state_next = ST_READ;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:   state_next = ST_IDLE;
            ST_SCROLL: begin
                if (scroll_last) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                if (fill_we && fill_last) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath, RAM control and result
    always_comb begin
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        idx_row_next   = idx_row_reg;
        idx_col_next   = idx_col_reg;
        fill_word_next = fill_word_reg;
        rd_ok_next     = rd_ok_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = {idx_row_reg, idx_col_reg};
        ram_wdata      = fill_word_reg;
        ram_raddr      = {RW'(s_data.row), CW'(s_data.col)};

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (s_data.cmd)
                        OP_PUT: begin
                            if (is_newline) begin
                                cur_col_next = '0;
                                if (at_bottom) begin
                                    idx_row_next   = '0;
                                    idx_col_next   = '0;
                                    fill_word_next = {s_data.color, BLANK_CODE};
                                end else begin
                                    cur_row_next = cur_row_reg + RW'(1);
                                end
                            end else begin
                                ram_we       = 1'b1;
                                ram_waddr    = {put_row, put_col};
                                ram_wdata    = {s_data.color, s_data.char_code};
                                cur_row_next = put_row;
                                cur_col_next = CCW'(put_col) + CCW'(1);
                            end
                        end
                        OP_SET: begin
                            if (row_ok) begin
                                cur_row_next = RW'(s_data.row);
                            end
                            if (col_ok) begin
                                cur_col_next = CCW'(s_data.col);
                            end
                        end
                        OP_CLEAR: begin
                            idx_row_next   = RW'(s_data.row);
                            idx_col_next   = '0;
                            fill_word_next = {color_reg, BLANK_CODE};
                        end
                        OP_HOME: begin
                            cur_row_next = '0;
                            cur_col_next = '0;
                        end
                        OP_READ: begin
                            rd_ok_next = row_ok && col_ok;
                        end
                        default: begin
                        end
                    endcase
                    // Commands that leave the engine in idle post their result right away.
                    if (state_next == ST_IDLE) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '{cursor_row: 5'(cur_row_next),
                                         cursor_col: 7'(cur_col_next),
                                         cell_word:  '0};
                    end
                end
            end
            ST_READ: begin
                m_valid_next = 1'b1;
                m_data_next  = '{cursor_row: 5'(cur_row_reg),
                                 cursor_col: 7'(cur_col_reg),
                                 cell_word:  rd_ok_reg ? ram_rdata : '0};
            end
            ST_SCROLL: begin
                // Read one row below, write it back in the following cycle.
                ram_raddr = {idx_row_reg + RW'(1), idx_col_reg};
                ram_we    = cp_valid_reg;
                ram_waddr = cp_addr_reg;
                ram_wdata = ram_rdata;
                if (scroll_last) begin
                    idx_row_next = RW'(ROWS - 1);
                    idx_col_next = '0;
                end else if (idx_col_reg == CW'(COLS - 1)) begin
                    idx_row_next = idx_row_reg + RW'(1);
                    idx_col_next = '0;
                end else begin
                    idx_col_next = idx_col_reg + CW'(1);
                end
            end
            ST_FILL: begin
                if (cp_valid_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = cp_addr_reg;
                    ram_wdata = ram_rdata;
                end else begin
                    ram_we       = 1'b1;
                    idx_col_next = idx_col_reg + CW'(1);
                    if (fill_last) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '{cursor_row: 5'(cur_row_reg),
                                         cursor_col: 7'(cur_col_reg),
                                         cell_word:  '0};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            color_reg    <= DEFAULT_COLOR_RST;
            clr_addr_reg <= '0;
            cp_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            cp_valid_reg <= (state_reg == ST_SCROLL);
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                color_reg <= cfg_wr_data;
            end
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_row_reg   <= idx_row_next;
        idx_col_reg   <= idx_col_next;
        fill_word_reg <= fill_word_next;
        rd_ok_reg     <= rd_ok_next;
        cp_addr_reg   <= {idx_row_reg, idx_col_reg};
        m_data_reg    <= m_data_next;
    end

    tcc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_screen (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[sim/tb_text_console_cursor_scroll.sv]
// Self-checking testbench for text_console_cursor_scroll: directed table, then random
// command streams with random stalls on both channels, checked against a local console model.
// Depends on tcc_pkg and the RTL of text_console_cursor_scroll.
module tb_text_console_cursor_scroll
    import tcc_pkg::*;
;

    localparam int ROWS = TCC_ROWS;
    localparam int COLS = TCC_COLS;
    localparam logic [2:0] OP_FIRST_SPARE = 3'd5;
    localparam logic [2:0] OP_LAST_SPARE  = 3'd7;
    localparam int RANDOM_PHASE_ITEMS = 345;
    localparam int HOLD_CYCLES        = 400;

    typedef struct {
        tcc_in_t  cmd_item;
        bit       fixed;
        tcc_out_t want;
    } stim_row_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    tcc_in_t    s_data;
    logic       m_valid;
    logic       m_ready;
    tcc_out_t   m_data;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    // console model state
    logic [15:0] screen [ROWS][COLS];
    int          cur_row;
    int          cur_col;
    logic [7:0]  clear_attr;
    int          scrolls_left;

    tcc_out_t    cursor_reports[$];
    bit          fixed_row;
    tcc_out_t    fixed_want;
    int          reports_seen;
    int          bad_reports;
    int          next_hold_at;
    int          calm_left;
    stim_row_t   directed[$];

    text_console_cursor_scroll i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #16000000;
        $display("tb_text_console_cursor_scroll NOT OK");
        $finish;
    end

    function automatic tcc_out_t apply_command(tcc_in_t it);
        tcc_out_t    rep;
        logic [15:0] cell_val;
        int          r;
        int          c;
        cell_val = '0;
        case (it.cmd)
            OP_PUT: begin
                if (it.char_code == NEWLINE_CODE) begin
                    cur_row++;
                    cur_col = 0;
                    if (cur_row >= ROWS) begin
                        // scroll up, blank the bottom row in the item's color
                        for (r = 0; r < ROWS - 1; r++)
                            for (c = 0; c < COLS; c++)
                                screen[r][c] = screen[r + 1][c];
                        for (c = 0; c < COLS; c++)
                            screen[ROWS - 1][c] = {it.color, BLANK_CODE};
                        cur_row = ROWS - 1;
                    end
                end else begin
                    if (cur_col >= COLS) begin
                        cur_row++;
                        cur_col = 0;
                    end
                    // wrap at the bottom clamps without scrolling
                    if (cur_row >= ROWS)
                        cur_row = ROWS - 1;
                    screen[cur_row][cur_col] = {it.color, it.char_code};
                    cur_col++;
                end
            end
            OP_SET: begin
                if (it.row < ROWS)
                    cur_row = it.row;
                if (it.col < COLS)
                    cur_col = it.col;
            end
            OP_CLEAR: begin
                if (it.row < ROWS)
                    for (c = 0; c < COLS; c++)
                        screen[it.row][c] = {clear_attr, BLANK_CODE};
            end
            OP_HOME: begin
                cur_row = 0;
                cur_col = 0;
            end
            OP_READ: begin
                if (it.row < ROWS && it.col < COLS)
                    cell_val = screen[it.row][it.col];
            end
            default: ;
        endcase
        rep.cursor_row = 5'(cur_row);
        rep.cursor_col = 7'(cur_col);
        rep.cell_word  = cell_val;
        return rep;
    endfunction

    function automatic stim_row_t stim(logic [2:0] cmd, logic [7:0] ch, logic [7:0] color,
                                       logic [4:0] r, logic [6:0] c, bit fixed,
                                       logic [4:0] er, logic [6:0] ec, logic [15:0] ew);
        stim_row_t s;
        s.cmd_item.cmd       = cmd;
        s.cmd_item.char_code = ch;
        s.cmd_item.color     = color;
        s.cmd_item.row       = r;
        s.cmd_item.col       = c;
        s.fixed              = fixed;
        s.want.cursor_row    = er;
        s.want.cursor_col    = ec;
        s.want.cell_word     = ew;
        return s;
    endfunction

    function automatic tcc_in_t random_command();
        tcc_in_t it;
        int      pick;
        it.cmd       = OP_PUT;
        it.char_code = 8'($urandom_range(0, 255));
        it.color     = 8'($urandom_range(0, 255));
        it.row       = 5'($urandom_range(0, 31));
        it.col       = 7'($urandom_range(0, 127));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            if ($urandom_range(0, 9) == 0)
                it.char_code = NEWLINE_CODE;
            // scrolls copy a whole screen: ration them
            if (it.char_code == NEWLINE_CODE && cur_row == ROWS - 1) begin
                if (scrolls_left > 0 && $urandom_range(0, 2) == 0)
                    scrolls_left--;
                else
                    it.char_code = BLANK_CODE;
            end
        end else if (pick < 67) begin
            it.cmd = OP_SET;
            if ($urandom_range(0, 6) != 0)
                it.row = 5'($urandom_range(0, ROWS - 1));
            if ($urandom_range(0, 2) == 0)
                it.col = 7'($urandom_range(COLS - 10, COLS - 1));
        end else if (pick < 75) begin
            it.cmd = OP_CLEAR;
        end else if (pick < 79) begin
            it.cmd = OP_HOME;
        end else if (pick < 96) begin
            it.cmd = OP_READ;
            if ($urandom_range(0, 9) != 0)
                it.col = 7'($urandom_range(0, COLS - 1));
        end else begin
            it.cmd = 3'($urandom_range(OP_FIRST_SPARE, OP_LAST_SPARE));
        end
        return it;
    endfunction

    function automatic int sender_gap();
        int pick;
        if (calm_left == 0 && $urandom_range(0, 29) == 0)
            calm_left = $urandom_range(20, 80);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic pause_sender();
        int g;
        g = sender_gap();
        repeat (g) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // call at a falling edge; hold until the transfer
    task automatic offer(input tcc_in_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    task automatic settle_and_config(input logic [7:0] attr);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (cursor_reports.size() != 0 || s_ready !== 1'b1)
            @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= attr;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic report_field(input string name, input int want, input int got);
        bad_reports++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    endtask

    always @(posedge aclk) begin
        tcc_out_t calc;
        tcc_out_t want;
        if (cfg_wr_en === 1'b1)
            clear_attr = cfg_wr_data;
        if (aresetn && s_valid && s_ready === 1'b1) begin
            calc = apply_command(s_data);
            cursor_reports.push_back(fixed_row ? fixed_want : calc);
        end
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            reports_seen++;
            if (cursor_reports.size() == 0) begin
                bad_reports++;
                $display("%0t: unexpected transfer, expected none, actual %0h",
                         $time, m_data);
            end else begin
                want = cursor_reports.pop_front();
                if (m_data.cursor_row !== want.cursor_row)
                    report_field("cursor_row", want.cursor_row, m_data.cursor_row);
                if (m_data.cursor_col !== want.cursor_col)
                    report_field("cursor_col", want.cursor_col, m_data.cursor_col);
                if (m_data.cell_word !== want.cell_word)
                    report_field("cell_word", want.cell_word, m_data.cell_word);
            end
        end
    end

    // receiver: random stalls, plus long hold-offs that back up the input
    initial begin
        int left;
        bit on;
        m_ready = 1'b0;
        left    = 0;
        on      = 1'b0;
        forever begin
            @(negedge aclk);
            if (reports_seen >= next_hold_at) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                next_hold_at += 600;
                left = 0;
            end
            if (left == 0) begin
                on = !on;
                if (on)
                    left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                       : $urandom_range(1, 12);
                else if ($urandom_range(0, 19) == 0)
                    left = $urandom_range(20, 40);
                else
                    left = $urandom_range(1, 4);
            end
            m_ready <= on;
            left--;
        end
    end

    initial begin
        logic [7:0] attrs [4];
        int         p;
        int         n;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        fixed_row    = 1'b0;
        fixed_want   = '0;
        reports_seen = 0;
        bad_reports  = 0;
        next_hold_at = 300;
        calm_left    = 0;
        scrolls_left = 60;
        cur_row      = 0;
        cur_col      = 0;
        clear_attr   = DEFAULT_COLOR_RST;
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLS; c++)
                screen[r][c] = '0;

        directed.push_back(stim(OP_READ,  8'h00, 8'h00, 5'd0,  7'd0,   1, 5'd0,  7'd0,  16'h0000));
        directed.push_back(stim(OP_READ,  8'h00, 8'h00, 5'd31, 7'd127, 1, 5'd0,  7'd0,  16'h0000));
        directed.push_back(stim(OP_PUT,   8'h41, 8'h1E, 5'd0,  7'd0,   1, 5'd0,  7'd1,  16'h0000));
        directed.push_back(stim(OP_READ,  8'h00, 8'h00, 5'd0,  7'd0,   1, 5'd0,  7'd1,  16'h1E41));
        directed.push_back(stim(OP_SET,   8'h00, 8'h00, 5'd24, 7'd79,  1, 5'd24, 7'd79, 16'h0000));
        directed.push_back(stim(OP_PUT,   8'hFF, 8'hFF, 5'd31, 7'd127, 1, 5'd24, 7'd80, 16'h0000));
        directed.push_back(stim(OP_READ,  8'h00, 8'h00, 5'd24, 7'd79,  1, 5'd24, 7'd80, 16'hFFFF));
        // wrap pending on the bottom row: clamp, overwrite column 0
        directed.push_back(stim(OP_PUT,   8'h01, 8'h80, 5'd0,  7'd0,   1, 5'd24, 7'd1,  16'h0000));
        directed.push_back(stim(OP_READ,  8'h00, 8'h00, 5'd24, 7'd0,   1, 5'd24, 7'd1,  16'h8001));
        directed.push_back(stim(OP_SET,   8'h00, 8'h00, 5'd31, 7'd127, 1, 5'd24, 7'd1,  16'h0000));
        directed.push_back(stim(OP_SET,   8'h00, 8'h00, 5'd25, 7'd5,   1, 5'd24, 7'd5,  16'h0000));
        directed.push_back(stim(OP_SET,   8'h00, 8'h00, 5'd3,  7'd80,  1, 5'd3,  7'd5,  16'h0000));
        directed.push_back(stim(OP_PUT, NEWLINE_CODE, 8'h42, 5'd0, 7'd0, 1, 5'd4, 7'd0, 16'h0000));
        directed.push_back(stim(OP_SET,   8'h00, 8'h00, 5'd24, 7'd10,  1, 5'd24, 7'd10, 16'h0000));
        // newline on the bottom row scrolls
        directed.push_back(stim(OP_PUT, NEWLINE_CODE, 8'h5A, 5'd0, 7'd0, 1, 5'd24, 7'd0, 16'h0000));
        directed.push_back(stim(OP_READ,  8'h00, 8'h00, 5'd24, 7'd40,  1, 5'd24, 7'd0,  16'h5A20));
        directed.push_back(stim(OP_READ,  8'h00, 8'h00, 5'd23, 7'd0,   1, 5'd24, 7'd0,  16'h8001));
        directed.push_back(stim(OP_CLEAR, 8'h00, 8'h00, 5'd5,  7'd0,   1, 5'd24, 7'd0,  16'h0000));
        directed.push_back(stim(OP_READ,  8'h00, 8'h00, 5'd5,  7'd79,  1, 5'd24, 7'd0,  16'h0720));
        directed.push_back(stim(OP_CLEAR, 8'h00, 8'h00, 5'd31, 7'd0,   1, 5'd24, 7'd0,  16'h0000));
        directed.push_back(stim(OP_READ,  8'h00, 8'h00, 5'd0,  7'd0,   0, 5'd0,  7'd0,  16'h0000));
        directed.push_back(stim(OP_HOME,  8'h00, 8'h00, 5'd0,  7'd0,   1, 5'd0,  7'd0,  16'h0000));
        directed.push_back(stim(OP_FIRST_SPARE, 8'h00, 8'h00, 5'd0, 7'd0, 1, 5'd0, 7'd0, 16'h0000));
        directed.push_back(stim(OP_FIRST_SPARE + 3'd1, 8'hFF, 8'hFF, 5'd31, 7'd127, 1,
                                5'd0, 7'd0, 16'h0000));
        directed.push_back(stim(OP_LAST_SPARE, 8'h00, 8'h00, 5'd0, 7'd0, 1, 5'd0, 7'd0, 16'h0000));

        attrs[0] = 8'h00;
        attrs[1] = 8'hFF;
        attrs[2] = 8'($urandom_range(1, 254));
        attrs[3] = 8'($urandom_range(0, 255));

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part runs with the reset default color
        for (n = 0; n < directed.size(); n++) begin
            pause_sender();
            @(negedge aclk);
            fixed_row  = directed[n].fixed;
            fixed_want = directed[n].want;
            offer(directed[n].cmd_item);
        end

        for (p = 0; p < 4; p++) begin
            settle_and_config(attrs[p]);
            for (n = 0; n < RANDOM_PHASE_ITEMS; n++) begin
                pause_sender();
                @(negedge aclk);
                fixed_row = 1'b0;
                offer(random_command());
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (cursor_reports.size() != 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (bad_reports == 0)
            $display("tb_text_console_cursor_scroll OK");
        else
            $display("tb_text_console_cursor_scroll NOT OK");
        $finish;
    end

endmodule

[files.f]
rtl/tcc_pkg.sv
rtl/tcc_ram.sv
rtl/text_console_cursor_scroll.sv
sim/tb_text_console_cursor_scroll.sv
